// File: sv/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg - shared definitions for the polynomial term parser
// Widths, character codes, saturation limits, result kinds, error codes and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

    // Term geometry
    localparam int NUM_LETTERS = 26;
    localparam int COEF_W      = 32;
    localparam int EXP_W       = 16;
    localparam int VALUE_W     = 32;
    localparam int EXT_W       = (COEF_W > VALUE_W) ? COEF_W : VALUE_W;
    localparam int LETTER_W    = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
    localparam int CNT_W       = $clog2(NUM_LETTERS + 1);

    // Port field widths
    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 2;
    localparam int OUT_LETTER_W = 5;
    localparam int CODE_W       = 3;
    localparam int M_TDATA_W    = 40;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [3:0]        RADIX    = 4'd10;

    // Saturation limits
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [EXP_W-1:0]  EXP_MAX  = {1'b0, {(EXP_W-1){1'b1}}};

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_COEF = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_SIGN   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_NUMBER = 3'd2;
    localparam logic [CODE_W-1:0] ERR_LETTER = 3'd3;
    localparam logic [CODE_W-1:0] ERR_EXPDIG = 3'd4;

    typedef enum logic [2:0] {
        PS_SIGN,
        PS_COEF,
        PS_LETTERS,
        PS_CARET,
        PS_EXPDIG,
        PS_ERROR
    } parse_state_t;

    typedef enum logic [1:0] {
        CS_IN,
        CS_EMIT,
        CS_ERR
    } ctl_state_t;

endpackage

`default_nettype wire

// File: sv/polynomial_term_parser.sv
// ----------------------------------------------------------------------------
// polynomial_term_parser - splits polynomial text into terms
// Parses one character per request; each finished term is sent as one
// coefficient result and one exponent result per letter, read from a RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                                   | tuser      | tlast
//  s_      | in        | [7:0] character                         | first_char | last_char
//  m_      | out       | [4:0] letter_index [36:5] value [39:37] err | kind     | last_of_term
//
//  A character that closes no term leaves the input ready for the next one.
//  A closed term is sent as 27 results, one per cycle while m_tready is high,
//  exponents read from the RAM; a sign that is also the last character closes two.
//  The input is held off while a term or an error result is being sent.
//  Reset clears the control state and the per-letter valid bits at once;
//  no clearing pass. m_tready low stalls the RAM read pipeline in place.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_term_parser (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ptp_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] character
    input  wire logic                           s_tuser,   // [0] first_char
    input  wire logic                           s_tlast,   // last_char
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ptp_pkg::M_TDATA_W-1:0]  m_tdata,   // letter_index, value, error_code
    output logic      [ptp_pkg::KIND_W-1:0]     m_tuser,   // [1:0] kind
    output logic                                m_tlast    // last_of_term
);

    import ptp_pkg::*;

    // Control state
    ctl_state_t   ctl_reg, ctl_next;
    parse_state_t parse_reg, parse_next;

    // Term state
    logic                   sign_reg, sign_next;
    logic [COEF_W-1:0]      coef_reg, coef_next;
    logic                   started_reg, started_next;
    logic [LETTER_W-1:0]    cur_reg, cur_next;
    logic [EXP_W-1:0]       acc_reg, acc_next;
    logic [NUM_LETTERS-1:0] lvalid_reg, lvalid_next;
    logic [CODE_W-1:0]      code_reg, code_next;

    // Sign held over a term it closed, and its last flag
    logic pend_sign_reg, pend_sign_next;
    logic pend_minus_reg, pend_minus_next;
    logic pend_last_reg, pend_last_next;

    // Emission read pipeline
    logic             issuing_reg, issuing_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             f_valid_reg, f_valid_next;
    logic [CNT_W-1:0] f_idx_reg, f_idx_next;
    logic             f_vbit_reg, f_vbit_next;

    // Output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0]       o_kind_reg, o_kind_next;
    logic [OUT_LETTER_W-1:0] o_letter_reg, o_letter_next;
    logic [VALUE_W-1:0]      o_value_reg, o_value_next;
    logic [CODE_W-1:0]       o_code_reg, o_code_next;
    logic                    o_last_reg, o_last_next;

    // RAM port
    logic                ram_we;
    logic [LETTER_W-1:0] ram_wr_addr;
    logic [EXP_W-1:0]    ram_wr_data;
    logic                ram_re;
    logic [LETTER_W-1:0] ram_rd_addr;
    logic [EXP_W-1:0]    ram_rd_data;

    // Character decode
    logic              is_sign, is_minus, is_digit, is_letter, is_caret;
    logic [CHAR_W-1:0] c_off;
    logic [LETTER_W-1:0] letter_idx;
    logic [3:0]        digit;

    logic             load_ok;
    logic [EXT_W-1:0] coef_base;
    logic [EXT_W-1:0] coef_signed;
    logic [CNT_W-1:0] rd_idx;

    ptp_ram #(
        .WIDTH (EXP_W),
        .DEPTH (NUM_LETTERS)
    ) u_exp_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign is_minus   = (s_tdata == CH_MINUS);
    assign is_sign    = (s_tdata == CH_PLUS) || is_minus;
    assign is_caret   = (s_tdata == CH_CARET);
    assign is_digit   = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign c_off      = s_tdata - CH_A;
    assign is_letter  = (s_tdata >= CH_A) && (c_off < CHAR_W'(NUM_LETTERS));
    assign letter_idx = LETTER_W'(c_off);
    assign digit      = s_tdata[3:0];

    assign load_ok  = !m_tvalid_reg || m_tready;
    assign s_tready = (ctl_reg == CS_IN);

    // Coefficient as sent: an unstarted term counts as all ones before the sign
    assign coef_base   = started_reg ? EXT_W'(coef_reg) : {EXT_W{1'b1}};
    assign coef_signed = sign_reg ? (~coef_base + EXT_W'(1)) : coef_base;

    assign rd_idx      = issue_cnt_reg - CNT_W'(1);
    assign ram_rd_addr = LETTER_W'(rd_idx);

    always_comb begin
        logic                  first;
        logic                  pre_emit;
        logic                  letter_hit;
        logic                  issue_ok;
        logic                  load;
        logic [CODE_W-1:0]     err;
        parse_state_t          ps;
        logic [COEF_W+3:0]     coef_x10;
        logic [EXP_W+3:0]      acc_x10;
        logic [EXP_W-1:0]      acc_sat;

        ctl_next        = ctl_reg;
        parse_next      = parse_reg;
        sign_next       = sign_reg;
        coef_next       = coef_reg;
        started_next    = started_reg;
        cur_next        = cur_reg;
        acc_next        = acc_reg;
        lvalid_next     = lvalid_reg;
        code_next       = code_reg;
        pend_sign_next  = pend_sign_reg;
        pend_minus_next = pend_minus_reg;
        pend_last_next  = pend_last_reg;
        issuing_next    = issuing_reg;
        issue_cnt_next  = issue_cnt_reg;
        f_valid_next    = f_valid_reg;
        f_idx_next      = f_idx_reg;
        f_vbit_next     = f_vbit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        o_kind_next     = o_kind_reg;
        o_letter_next   = o_letter_reg;
        o_value_next    = o_value_reg;
        o_code_next     = o_code_reg;
        o_last_next     = o_last_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = cur_reg;
        ram_wr_data     = '0;
        ram_re          = 1'b0;

        first      = s_tuser;
        pre_emit   = 1'b0;
        letter_hit = 1'b0;
        issue_ok   = 1'b0;
        load       = 1'b0;
        err        = ERR_NONE;
        ps         = parse_reg;
        coef_x10   = '0;
        acc_x10    = '0;
        acc_sat    = '0;

        unique case (ctl_reg)
            CS_IN: begin
                if (s_tvalid) begin
                    if (first) begin
                        sign_next    = 1'b0;
                        coef_next    = '0;
                        started_next = 1'b0;
                        cur_next     = '0;
                        acc_next     = '0;
                        lvalid_next  = '0;
                        ps           = is_sign ? PS_SIGN : PS_COEF;
                    end

                    coef_x10 = ((COEF_W+4)'(coef_next) * (COEF_W+4)'(RADIX))
                               + (COEF_W+4)'(digit);
                    acc_x10  = ((EXP_W+4)'(acc_next) * (EXP_W+4)'(RADIX))
                               + (EXP_W+4)'(digit);
                    acc_sat  = (acc_x10 > (EXP_W+4)'(EXP_MAX)) ? EXP_MAX
                                                                : EXP_W'(acc_x10);

                    unique case (ps)
                        PS_SIGN: begin
                            if (is_sign) begin
                                sign_next = is_minus;
                                ps        = PS_COEF;
                            end else begin
                                err = ERR_SIGN;
                            end
                        end
                        PS_COEF: begin
                            if (is_digit) begin
                                coef_next = (coef_x10 > (COEF_W+4)'(COEF_MAX))
                                            ? COEF_MAX : COEF_W'(coef_x10);
                                started_next = 1'b1;
                            end else if (is_letter) begin
                                if (!started_next) begin
                                    coef_next = COEF_W'(1);
                                end
                                started_next = 1'b1;
                                letter_hit   = 1'b1;
                            end else if (is_sign && started_next) begin
                                pre_emit = 1'b1;
                            end else begin
                                err = ERR_NUMBER;
                            end
                        end
                        PS_LETTERS: begin
                            if (is_letter) begin
                                letter_hit = 1'b1;
                            end else if (is_caret) begin
                                acc_next = '0;
                                ps       = PS_CARET;
                            end else if (is_sign) begin
                                pre_emit = 1'b1;
                            end else begin
                                err = ERR_LETTER;
                            end
                        end
                        PS_CARET, PS_EXPDIG: begin
                            if (is_digit) begin
                                acc_next              = acc_sat;
                                ram_we                = 1'b1;
                                ram_wr_addr           = cur_next;
                                ram_wr_data           = acc_sat;
                                lvalid_next[cur_next] = 1'b1;
                                ps                    = PS_EXPDIG;
                            end else if (is_letter && (acc_next != '0)) begin
                                letter_hit = 1'b1;
                            end else if (is_sign) begin
                                // caret with no digit before the sign: power zero
                                if (ps == PS_CARET) begin
                                    ram_we                = 1'b1;
                                    ram_wr_addr           = cur_next;
                                    ram_wr_data           = '0;
                                    lvalid_next[cur_next] = 1'b1;
                                end
                                pre_emit = 1'b1;
                            end else begin
                                err = ERR_EXPDIG;
                            end
                        end
                        PS_ERROR: begin
                        end
                        default: begin
                        end
                    endcase

                    if (letter_hit) begin
                        cur_next                = letter_idx;
                        ram_we                  = 1'b1;
                        ram_wr_addr             = letter_idx;
                        ram_wr_data             = EXP_W'(1);
                        lvalid_next[letter_idx] = 1'b1;
                        ps                      = PS_LETTERS;
                    end

                    if (err != ERR_NONE) begin
                        sign_next    = 1'b0;
                        coef_next    = '0;
                        started_next = 1'b0;
                        cur_next     = '0;
                        acc_next     = '0;
                        lvalid_next  = '0;
                        code_next    = err;
                        parse_next   = PS_ERROR;
                        ctl_next     = CS_ERR;
                    end else if (pre_emit) begin
                        // the sign opens the next term once this one is sent
                        pend_sign_next  = 1'b1;
                        pend_minus_next = is_minus;
                        pend_last_next  = s_tlast;
                        parse_next      = ps;
                        ctl_next        = CS_EMIT;
                        issuing_next    = 1'b1;
                        issue_cnt_next  = '0;
                    end else begin
                        parse_next = ps;
                        if (s_tlast && (ps != PS_ERROR)) begin
                            pend_sign_next = 1'b0;
                            ctl_next       = CS_EMIT;
                            issuing_next   = 1'b1;
                            issue_cnt_next = '0;
                        end
                    end
                end
            end

            CS_EMIT: begin
                load     = f_valid_reg && load_ok;
                issue_ok = issuing_reg && (!f_valid_reg || load_ok);

                if (issue_ok) begin
                    ram_re         = (issue_cnt_reg != '0);
                    f_idx_next     = issue_cnt_reg;
                    f_vbit_next    = (issue_cnt_reg != '0) && lvalid_reg[ram_rd_addr];
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    if (issue_cnt_reg == CNT_W'(NUM_LETTERS)) begin
                        issuing_next = 1'b0;
                    end
                end
                f_valid_next = issue_ok ? 1'b1 : (load ? 1'b0 : f_valid_reg);

                if (load) begin
                    m_tvalid_next = 1'b1;
                    o_code_next   = ERR_NONE;
                    if (f_idx_reg == '0) begin
                        o_kind_next   = KIND_COEF;
                        o_letter_next = '0;
                        o_value_next  = VALUE_W'(coef_signed);
                        o_last_next   = 1'b0;
                    end else begin
                        o_kind_next   = KIND_EXP;
                        o_letter_next = OUT_LETTER_W'(f_idx_reg - CNT_W'(1));
                        o_value_next  = f_vbit_reg ? VALUE_W'(ram_rd_data) : '0;
                        o_last_next   = (f_idx_reg == CNT_W'(NUM_LETTERS));
                    end

                    if (f_idx_reg == CNT_W'(NUM_LETTERS)) begin
                        sign_next    = 1'b0;
                        coef_next    = '0;
                        started_next = 1'b0;
                        cur_next     = '0;
                        acc_next     = '0;
                        lvalid_next  = '0;
                        if (pend_sign_reg) begin
                            sign_next      = pend_minus_reg;
                            parse_next     = PS_COEF;
                            pend_sign_next = 1'b0;
                            if (pend_last_reg) begin
                                // bare trailing sign closes a second, empty term
                                pend_last_next = 1'b0;
                                issuing_next   = 1'b1;
                                issue_cnt_next = '0;
                            end else begin
                                ctl_next = CS_IN;
                            end
                        end else begin
                            parse_next = PS_SIGN;
                            ctl_next   = CS_IN;
                        end
                    end
                end
            end

            CS_ERR: begin
                if (load_ok) begin
                    m_tvalid_next = 1'b1;
                    o_kind_next   = KIND_ERR;
                    o_letter_next = '0;
                    o_value_next  = '0;
                    o_code_next   = code_reg;
                    o_last_next   = 1'b1;
                    ctl_next      = CS_IN;
                end
            end

            default: begin
                ctl_next = CS_IN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg        <= CS_IN;
            parse_reg      <= PS_SIGN;
            sign_reg       <= 1'b0;
            coef_reg       <= '0;
            started_reg    <= 1'b0;
            cur_reg        <= '0;
            acc_reg        <= '0;
            lvalid_reg     <= '0;
            pend_sign_reg  <= 1'b0;
            pend_last_reg  <= 1'b0;
            issuing_reg    <= 1'b0;
            issue_cnt_reg  <= '0;
            f_valid_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            ctl_reg        <= ctl_next;
            parse_reg      <= parse_next;
            sign_reg       <= sign_next;
            coef_reg       <= coef_next;
            started_reg    <= started_next;
            cur_reg        <= cur_next;
            acc_reg        <= acc_next;
            lvalid_reg     <= lvalid_next;
            pend_sign_reg  <= pend_sign_next;
            pend_last_reg  <= pend_last_next;
            issuing_reg    <= issuing_next;
            issue_cnt_reg  <= issue_cnt_next;
            f_valid_reg    <= f_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg       <= code_next;
        pend_minus_reg <= pend_minus_next;
        f_idx_reg      <= f_idx_next;
        f_vbit_reg     <= f_vbit_next;
        o_kind_reg     <= o_kind_next;
        o_letter_reg   <= o_letter_next;
        o_value_reg    <= o_value_next;
        o_code_reg     <= o_code_next;
        o_last_reg     <= o_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_code_reg, o_value_reg, o_letter_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

    // Characters are only taken with the read pipeline drained
    a_pipe_empty_on_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !f_valid_reg)
        else $error("read pipeline busy while taking characters");

    // Letter writes and emission reads never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re)
        else $error("RAM write during emission read");

    // A coefficient result never closes a term
    a_coef_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_COEF)) |-> !m_tlast)
        else $error("coefficient result marked last");

    // Error results are last and carry a zero value
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERR)) |-> (m_tlast && (o_value_reg == '0)))
        else $error("malformed error result");

endmodule

`default_nettype wire

// File: sv/ptp_ram.sv
// ----------------------------------------------------------------------------
// ptp_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 26,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
